>>> src/ssl_pkg.sv
// Shared types and constants of the storage setpoint limiter.
package ssl_pkg;

	localparam int unsigned MulAW = 48;
	localparam int unsigned MulBW = 17;
	localparam int unsigned DivNW = 48;
	localparam int unsigned DivDW = 32;
	localparam logic signed [17:0] OneQ16 = 18'sd65536;
	localparam logic signed [17:0] StorageMinFrac = 18'sd16;

	typedef enum logic [2:0] {
		CFG_RATED_POWER = 3'd0,
		CFG_MIN_FRACTION = 3'd1,
		CFG_MAX_FRACTION = 3'd2,
		CFG_CAPACITY = 3'd3,
		CFG_INIT_CHARGE = 3'd4,
		CFG_INIT_SETPOINT = 3'd5,
		CFG_EXT_CONTROL = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INT_M1,
		ST_INT_M2,
		ST_INT_D,
		ST_LIM_M1,
		ST_LIM_M2,
		ST_LIM_D1,
		ST_LIM_M3,
		ST_LIM_D2,
		ST_CLAMP,
		ST_POW_M,
		ST_OUT
	} state_t;

endpackage

>>> src/storage_setpoint_limiter_soc_core.sv
// Top level of the storage setpoint limiter with its sequencer and state.
// A request runs up to six serial multiplies and three serial divides, then one clamp and one
// output step; the integration and limit steps are skipped when they are not enabled. A new
// request is taken only back in idle, after the result is registered; an output stall holds
// the sequencer in its output state until the result is taken.
// Reset loads the register reset values, charge one half and setpoint zero.
module storage_setpoint_limiter_soc_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [16:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [15:0] elapsed_seconds,
	input logic signed [15:0] setpoint,
	input logic setpoint_valid,
	output logic out_valid,
	input logic out_stall,
	output logic signed [15:0] applied_setpoint,
	output logic signed [17:0] power_kw,
	output logic [15:0] reserve_up,
	output logic [15:0] reserve_down,
	output logic signed [17:0] charge_level,
	output logic fault,
	output logic store_full,
	output logic store_empty,
	output logic is_storage
);
	ssl_pkg::state_t state_q, state_d;

	logic [15:0] rated_q;
	logic signed [15:0] min_q;
	logic signed [15:0] max_q;
	logic [15:0] cap_q;
	logic ext_q;
	logic signed [15:0] sp_q;
	logic signed [17:0] chg_q;
	logic [15:0] dt_q;
	logic signed [15:0] req_q;
	logic sv_q;
	logic launched_q;
	logic [31:0] den_q;
	logic [16:0] emax_q;
	logic [16:0] emin_q;
	logic out_valid_q;

	logic mul_start, div_start, mul_done, div_done;
	logic [ssl_pkg::MulAW-1:0] mul_a, mul_p;
	logic [ssl_pkg::MulBW-1:0] mul_b;
	logic [ssl_pkg::DivNW-1:0] div_n, div_q;
	logic [ssl_pkg::DivDW-1:0] div_d;

	logic [15:0] pw;
	logic [25:0] cap900;
	logic storage, full, empty, blocked, int_en, lim_en;
	logic [16:0] sp_abs;
	logic [16:0] room;
	logic signed [17:0] lo1, hi1, lo2, hi2;
	logic signed [15:0] sp_clamp;
	logic [19:0] qsat;
	logic signed [20:0] nb;
	logic signed [17:0] nb_sat;
	logic [16:0] qlim;
	logic [32:0] pround;
	logic signed [18:0] pmag;
	logic signed [17:0] pval;
	logic signed [16:0] up_v, down_v;
	logic accept_in, load_out;

	function automatic logic faulted(input logic signed [15:0] sp, input logic signed [17:0] c,
			input logic signed [15:0] mn, input logic signed [15:0] mx);
		faulted = sp < mn || sp > mx || c < 18'sd0 || c > ssl_pkg::OneQ16;
	endfunction

	function automatic logic signed [17:0] lim_lo(input logic flt, input logic en,
			input logic signed [15:0] mn, input logic [16:0] emin);
		logic signed [17:0] v;
		logic signed [17:0] e;
		v = flt ? 18'sd0 : 18'(mn);
		e = -$signed({1'b0, emin});
		if (!flt && en && e > v) begin
			v = e;
		end
		lim_lo = v;
	endfunction

	function automatic logic signed [17:0] lim_hi(input logic flt, input logic en,
			input logic signed [15:0] mx, input logic [16:0] emax);
		logic signed [17:0] v;
		logic signed [17:0] e;
		v = flt ? 18'sd0 : 18'(mx);
		e = $signed({1'b0, emax});
		if (!flt && en && e < v) begin
			v = e;
		end
		lim_hi = v;
	endfunction

	assign pw = (rated_q == 16'd0) ? 16'd1 : rated_q;
	assign cap900 = {cap_q, 10'b0} - {3'b0, cap_q, 7'b0} + {8'b0, cap_q, 2'b0};
	assign storage = 18'(min_q) <= ssl_pkg::StorageMinFrac && cap_q != 16'd0;
	assign full = storage && chg_q >= ssl_pkg::OneQ16;
	assign empty = storage && chg_q <= 18'sd0;
	assign blocked = (full && sp_q <= 16'sd0) || (empty && sp_q >= 16'sd0);
	assign int_en = storage && dt_q != 16'd0 && !blocked && sp_q != 16'sd0;
	assign lim_en = storage && dt_q != 16'd0 && chg_q >= 18'sd0 && chg_q <= ssl_pkg::OneQ16;
	assign sp_abs = sp_q[15] ? 17'(-18'(sp_q)) : 17'(sp_q);
	assign room = 17'(ssl_pkg::OneQ16 - chg_q);

	assign lo1 = lim_lo(faulted(sp_q, chg_q, min_q, max_q), lim_en, min_q, emin_q);
	assign hi1 = lim_hi(faulted(sp_q, chg_q, min_q, max_q), lim_en, max_q, emax_q);
	assign lo2 = lo1;
	assign hi2 = hi1;

	always_comb begin
		if (18'(req_q) >= hi1) begin
			sp_clamp = 16'(hi1);
		end else if (18'(req_q) <= lo1) begin
			sp_clamp = 16'(lo1);
		end else begin
			sp_clamp = req_q;
		end
		if (full && sp_clamp <= 16'sd0) begin
			sp_clamp = 16'sd0;
		end else if (empty && sp_clamp >= 16'sd0) begin
			sp_clamp = 16'sd0;
		end
	end

	assign qsat = (div_q[ssl_pkg::DivNW-1:19] != '0) ? 20'h80000 : {1'b0, div_q[18:0]};
	assign nb = sp_q[15] ? 21'(chg_q) + $signed({1'b0, qsat}) : 21'(chg_q) - $signed({1'b0, qsat});
	assign nb_sat = (nb > 21'sd131071) ? 18'sd131071 :
			(nb < -21'sd131072) ? -18'sd131072 : 18'(nb);
	assign qlim = (div_q[ssl_pkg::DivNW-1:16] != '0) ? 17'h10000 : {1'b0, div_q[15:0]};

	assign pround = {1'b0, mul_p[31:0]} + 33'd8192;
	assign pmag = $signed(pround[32:14]);
	assign pval = blocked ? 18'sd0 : (sp_q[15] ? 18'(-pmag) : 18'(pmag));
	assign up_v = 17'(hi2 - 18'(sp_q));
	assign down_v = 17'(18'(sp_q) - lo2);

	assign accept_in = in_valid && !in_stall;
	assign load_out = state_q == ssl_pkg::ST_OUT && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssl_pkg::ST_IDLE: if (accept_in) state_d = ssl_pkg::ST_INT_M1;
			ssl_pkg::ST_INT_M1: begin
				if (!int_en) state_d = ssl_pkg::ST_LIM_M1;
				else if (mul_done) state_d = ssl_pkg::ST_INT_M2;
			end
			ssl_pkg::ST_INT_M2: if (mul_done) state_d = ssl_pkg::ST_INT_D;
			ssl_pkg::ST_INT_D: if (div_done) state_d = ssl_pkg::ST_LIM_M1;
			ssl_pkg::ST_LIM_M1: begin
				if (!lim_en) state_d = ssl_pkg::ST_CLAMP;
				else if (mul_done) state_d = ssl_pkg::ST_LIM_M2;
			end
			ssl_pkg::ST_LIM_M2: if (mul_done) state_d = ssl_pkg::ST_LIM_D1;
			ssl_pkg::ST_LIM_D1: if (div_done) state_d = ssl_pkg::ST_LIM_M3;
			ssl_pkg::ST_LIM_M3: if (mul_done) state_d = ssl_pkg::ST_LIM_D2;
			ssl_pkg::ST_LIM_D2: if (div_done) state_d = ssl_pkg::ST_CLAMP;
			ssl_pkg::ST_CLAMP: state_d = ssl_pkg::ST_POW_M;
			ssl_pkg::ST_POW_M: if (mul_done) state_d = ssl_pkg::ST_OUT;
			ssl_pkg::ST_OUT: if (load_out) state_d = ssl_pkg::ST_IDLE;
			default: state_d = ssl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_n = '0;
		div_d = '0;
		case (state_q)
			ssl_pkg::ST_INT_M1: begin
				mul_start = int_en && !launched_q;
				mul_a = 48'(pw);
				mul_b = sp_abs;
			end
			ssl_pkg::ST_INT_M2: begin
				mul_start = !launched_q;
				mul_a = 48'(mul_p[31:0]);
				mul_b = 17'(dt_q);
			end
			ssl_pkg::ST_INT_D: begin
				div_start = !launched_q;
				div_n = mul_p + 48'(cap900[25:1]);
				div_d = 32'(cap900);
			end
			ssl_pkg::ST_LIM_M1: begin
				mul_start = lim_en && !launched_q;
				mul_a = 48'(pw);
				mul_b = 17'(dt_q);
			end
			ssl_pkg::ST_LIM_M2: begin
				mul_start = !launched_q;
				mul_a = 48'(cap900);
				mul_b = chg_q[16:0];
			end
			ssl_pkg::ST_LIM_D1, ssl_pkg::ST_LIM_D2: begin
				div_start = !launched_q;
				div_n = mul_p;
				div_d = den_q;
			end
			ssl_pkg::ST_LIM_M3: begin
				mul_start = !launched_q;
				mul_a = 48'(cap900);
				mul_b = room;
			end
			ssl_pkg::ST_POW_M: begin
				mul_start = !launched_q;
				mul_a = 48'(pw);
				mul_b = sp_abs;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign in_stall = state_q != ssl_pkg::ST_IDLE;

	ssl_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.prod(mul_p),
		.done(mul_done)
	);

	ssl_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_n),
		.den(div_d),
		.quo(div_q),
		.done(div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssl_pkg::ST_IDLE;
			launched_q <= 1'b0;
			out_valid_q <= 1'b0;
			rated_q <= 16'd1000;
			min_q <= -16'sd16384;
			max_q <= 16'sd16384;
			cap_q <= 16'd0;
			ext_q <= 1'b1;
			sp_q <= 16'sd0;
			chg_q <= 18'sd32768;
		end else begin
			state_q <= state_d;
			if (mul_done || div_done) begin
				launched_q <= 1'b0;
			end else if (mul_start || div_start) begin
				launched_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					ssl_pkg::CFG_RATED_POWER: rated_q <= cfg_data[15:0];
					ssl_pkg::CFG_MIN_FRACTION: min_q <= $signed(cfg_data[15:0]);
					ssl_pkg::CFG_MAX_FRACTION: max_q <= $signed(cfg_data[15:0]);
					ssl_pkg::CFG_CAPACITY: cap_q <= cfg_data[15:0];
					ssl_pkg::CFG_INIT_CHARGE: chg_q <= $signed({1'b0, cfg_data});
					ssl_pkg::CFG_INIT_SETPOINT: sp_q <= $signed(cfg_data[15:0]);
					ssl_pkg::CFG_EXT_CONTROL: ext_q <= cfg_data[0];
					default: ext_q <= ext_q;
				endcase
			end
			if (state_q == ssl_pkg::ST_INT_D && div_done) begin
				chg_q <= nb_sat;
			end
			if (state_q == ssl_pkg::ST_CLAMP && sv_q) begin
				sp_q <= sp_clamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			dt_q <= elapsed_seconds;
			req_q <= setpoint;
			sv_q <= setpoint_valid;
		end
		if (state_q == ssl_pkg::ST_LIM_M1 && mul_done) begin
			den_q <= mul_p[31:0];
		end
		if (state_q == ssl_pkg::ST_LIM_D1 && div_done) begin
			emax_q <= qlim;
		end
		if (state_q == ssl_pkg::ST_LIM_D2 && div_done) begin
			emin_q <= qlim;
		end
		if (load_out) begin
			applied_setpoint <= sp_q;
			power_kw <= pval;
			reserve_up <= (!ext_q || up_v <= 17'sd0 || empty) ? 16'd0 : 16'(up_v);
			reserve_down <= (!ext_q || down_v <= 17'sd0 || full) ? 16'd0 : 16'(down_v);
			charge_level <= chg_q;
			fault <= faulted(sp_q, chg_q, min_q, max_q);
			store_full <= full;
			store_empty <= empty;
			is_storage <= storage;
		end
	end

	assign out_valid = out_valid_q;
endmodule

>>> src/ssl_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module ssl_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [ssl_pkg::MulAW-1:0] a,
	input logic [ssl_pkg::MulBW-1:0] b,
	output logic [ssl_pkg::MulAW-1:0] prod,
	output logic done
);
	logic [ssl_pkg::MulAW-1:0] acc_q;
	logic [ssl_pkg::MulAW-1:0] a_q;
	logic [ssl_pkg::MulBW-1:0] b_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(ssl_pkg::MulBW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[ssl_pkg::MulAW-2:0], 1'b0};
			b_q <= {1'b0, b_q[ssl_pkg::MulBW-1:1]};
		end
	end

	assign prod = acc_q;
	assign done = done_q;
endmodule

>>> src/ssl_div.sv
// Restoring divider that produces one quotient bit per cycle.
module ssl_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [ssl_pkg::DivNW-1:0] num,
	input logic [ssl_pkg::DivDW-1:0] den,
	output logic [ssl_pkg::DivNW-1:0] quo,
	output logic done
);
	logic [ssl_pkg::DivDW-1:0] rem_q;
	logic [ssl_pkg::DivNW-1:0] quo_q;
	logic [ssl_pkg::DivDW-1:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [ssl_pkg::DivDW:0] shifted;
	logic [ssl_pkg::DivDW:0] trial;

	assign shifted = {rem_q, quo_q[ssl_pkg::DivNW-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(ssl_pkg::DivNW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[ssl_pkg::DivDW]) begin
				rem_q <= trial[ssl_pkg::DivDW-1:0];
			end else begin
				rem_q <= shifted[ssl_pkg::DivDW-1:0];
			end
			quo_q <= {quo_q[ssl_pkg::DivNW-2:0], ~trial[ssl_pkg::DivDW]};
		end
	end

	assign quo = quo_q;
	assign done = done_q;
endmodule
